### sv/rgb_blend_mode_unit_defines.svh
// ---------------------------------------------------------------------------
// RGB blend mode unit: assertion macros
// Concurrent assertion helpers, empty when synthesizing.
// ---------------------------------------------------------------------------
`ifndef RGB_BLEND_MODE_UNIT_DEFINES_SVH
`define RGB_BLEND_MODE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property while reset is released
`define RBM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("rbm assertion failed");
// Check a property on every edge, reset included
`define RBM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("rbm assertion failed");
`else
`define RBM_ASSERT(lbl, clk, rst_n, prop)
`define RBM_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### sv/rbm_pkg.sv
// ---------------------------------------------------------------------------
// RGB blend mode unit package
// Types and constants shared by the lanes, the merge stage and the top level.
// ---------------------------------------------------------------------------
package rbm_pkg;

    localparam int CHAN_W   = 8;
    localparam int SCALE_W  = 16;
    localparam int PROD_W   = CHAN_W + SCALE_W;
    localparam int NUM_LANE = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = SCALE_W;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_MODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = 1'b1;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;
    localparam logic [CHAN_W-1:0]  CHAN_MAX    = 8'd255;

    typedef enum logic [1:0] {
        MODE_MULTIPLY = 2'd0,
        MODE_SUBTRACT = 2'd1,
        MODE_SCALE    = 2'd2,
        MODE_OVERLAY  = 2'd3
    } t_mode;

    // Control from the top level to every lane
    typedef struct packed {
        logic               load;
        t_mode              mode;
        logic [SCALE_W-1:0] scale;
    } t_lane_ctrl;

endpackage

### sv/rbm_lane.sv
// ---------------------------------------------------------------------------
// RGB blend mode lane
// One color channel: operand select and multiply in a register stage, then
// divide by 510, rounding, saturation and overlay inversion after it.
// ---------------------------------------------------------------------------
module rbm_lane (
    input  logic                       i_clk,
    input  rbm_pkg::t_lane_ctrl        i_ctrl,
    input  logic [rbm_pkg::CHAN_W-1:0] i_top,
    input  logic [rbm_pkg::CHAN_W-1:0] i_bottom,
    output logic [rbm_pkg::CHAN_W-1:0] o_result
);
    import rbm_pkg::*;

    logic [CHAN_W-1:0]  w_x;
    logic [SCALE_W-1:0] w_y;
    logic [CHAN_W-1:0]  w_diff;
    logic [PROD_W-1:0]  r_prod;
    logic [PROD_W-1:0]  n_prod;
    logic               r_hi;

    logic [16:0]        w_num;
    logic [15:0]        w_half;
    logic [23:0]        w_recip;
    logic [CHAN_W-1:0]  w_q0;
    logic [16:0]        w_rem;
    logic [8:0]         w_quot;
    logic [CHAN_W-1:0]  w_q;
    logic [24:0]        w_scaled;

    // Select multiplier operands for the mode
    always_comb begin
        w_x    = i_top;
        w_y    = {{(SCALE_W-CHAN_W){1'b0}}, i_bottom};
        w_diff = (i_top > i_bottom) ? (i_top - i_bottom) : '0;
        case (i_ctrl.mode)
            MODE_SCALE: begin
                w_y = i_ctrl.scale;
            end
            MODE_OVERLAY: begin
                if (i_bottom[CHAN_W-1]) begin
                    w_x = CHAN_MAX - i_top;
                    w_y = {{(SCALE_W-CHAN_W){1'b0}}, CHAN_MAX - i_bottom};
                end
            end
            default: begin
            end
        endcase
        if (i_ctrl.mode == MODE_SUBTRACT) begin
            n_prod = {{(PROD_W-CHAN_W){1'b0}}, w_diff};
        end else begin
            n_prod = {{(PROD_W-CHAN_W){1'b0}}, w_x} * {{(PROD_W-SCALE_W){1'b0}}, w_y};
        end
    end

    // Hold the product while the pipeline stalls
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_prod <= n_prod;
            r_hi   <= i_bottom[CHAN_W-1];
        end
    end

    // Round-half-up divide by 255: (k*p + 255) / 510, k = 2 or 4
    always_comb begin
        if (i_ctrl.mode == MODE_OVERLAY) begin
            w_num = {r_prod[14:0], 2'b00} + 17'd255;
        end else begin
            w_num = {r_prod[15:0], 1'b0} + 17'd255;
        end
        w_half  = w_num[16:1];
        // Reciprocal estimate m*257/65536 is exact or one low
        w_recip = {w_half, 8'd0} + {8'd0, w_half};
        w_q0    = w_recip[23:16];
        w_rem   = {1'b0, w_half} - ({1'b0, w_q0, 8'd0} - {9'd0, w_q0});
        w_quot  = {1'b0, w_q0} + ((w_rem >= 17'd255) ? 9'd1 : 9'd0);
        w_q     = w_quot[7:0];
        w_scaled = {1'b0, r_prod} + 25'd128;
    end

    // Finish the channel for the active mode
    always_comb begin
        case (i_ctrl.mode)
            MODE_MULTIPLY: begin
                o_result = w_q;
            end
            MODE_SUBTRACT: begin
                o_result = r_prod[CHAN_W-1:0];
            end
            MODE_SCALE: begin
                o_result = (w_scaled[24:8] > 17'd255) ? CHAN_MAX : w_scaled[15:8];
            end
            MODE_OVERLAY: begin
                if (r_hi) begin
                    o_result = (w_q == CHAN_MAX) ? '0 : (CHAN_MAX - w_q);
                end else begin
                    o_result = w_q;
                end
            end
            default: begin
                o_result = w_q;
            end
        endcase
    end

endmodule

### sv/rbm_merge.sv
// ---------------------------------------------------------------------------
// RGB blend mode merge stage
// Collects the three lane results and the equality flag into the output
// register and runs the master-side handshake.
// ---------------------------------------------------------------------------
module rbm_merge (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_valid,
    input  logic [rbm_pkg::NUM_LANE*rbm_pkg::CHAN_W-1:0] i_lanes,
    input  logic                                       i_equal,
    output logic                                       o_take,
    output logic                                       o_m_axis_tvalid,
    input  logic                                       i_m_axis_tready,
    // tdata: out_red [7:0], out_green [15:8], out_blue [23:16]
    output logic [rbm_pkg::NUM_LANE*rbm_pkg::CHAN_W-1:0] o_m_axis_tdata,
    // tuser: pixels_equal [0]
    output logic                                       o_m_axis_tuser
);
    import rbm_pkg::*;

    logic                         r_valid;
    logic                         n_valid;
    logic [NUM_LANE*CHAN_W-1:0]   r_data;
    logic                         r_equal;

    // Load a new request when the register is empty or being drained
    assign o_take = !r_valid || i_m_axis_tready;

    always_comb begin
        n_valid = r_valid;
        if (o_take) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_data  <= i_lanes;
            r_equal <= i_equal;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = r_data;
    assign o_m_axis_tuser  = r_equal;

endmodule

### sv/rgb_blend_mode_unit.sv
// ---------------------------------------------------------------------------
// RGB blend mode unit
// Per-channel RGB888 blend of a top and a bottom pixel in three lanes.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream carries one pixel pair per request: top red, green, blue
//   in tdata[23:0], bottom red, green, blue in tdata[47:24]. Master stream
//   returns the blended pixel in tdata[23:0] and the pixels-equal flag in
//   tuser. Each request gives exactly one result, in order.
//   Mode and scale factor are written through the plain write port
//   (index 0 blend mode, index 1 scale factor, 8.8 unsigned) while the
//   stream is idle.
// Pipeline:
//   Operand select and the 8x16 multiply per lane in the first stage, then
//   the divide-by-255 rounding ahead of the output register in the merge stage.
//   One pixel per clock sustained while tready stays high.
// Reset and stall:
//   Synchronous active-low reset empties the pipeline and loads mode
//   multiply and scale 1.0. While the receiver holds tready low the output
//   holds; an empty multiply stage still takes one more request while
//   tready is low.
// ---------------------------------------------------------------------------
`include "rgb_blend_mode_unit_defines.svh"

module rgb_blend_mode_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rbm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rbm_pkg::CFG_DAT_W-1:0]  i_cfg_wdata,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // tdata: top_red [7:0], top_green [15:8], top_blue [23:16],
    //        bottom_red [31:24], bottom_green [39:32], bottom_blue [47:40]
    input  logic [2*rbm_pkg::NUM_LANE*rbm_pkg::CHAN_W-1:0] i_s_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // tdata: out_red [7:0], out_green [15:8], out_blue [23:16]
    output logic [rbm_pkg::NUM_LANE*rbm_pkg::CHAN_W-1:0] o_m_axis_tdata,
    // tuser: pixels_equal [0]
    output logic                           o_m_axis_tuser
);
    import rbm_pkg::*;

    localparam int PIX_W = NUM_LANE * CHAN_W;

    t_mode                 r_mode;
    logic [SCALE_W-1:0]    r_scale;
    logic                  r_v1;
    logic                  n_v1;
    logic                  r_eq1;
    logic                  w_take;
    logic                  w_en1;
    logic                  w_in_fire;
    logic [PIX_W-1:0]      w_top;
    logic [PIX_W-1:0]      w_bottom;
    logic [PIX_W-1:0]      w_lanes;
    t_lane_ctrl            w_ctrl;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_MULTIPLY;
            r_scale <= SCALE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BLEND_MODE:   r_mode  <= t_mode'(i_cfg_wdata[1:0]);
                REG_SCALE_FACTOR: r_scale <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign w_top    = i_s_axis_tdata[PIX_W-1:0];
    assign w_bottom = i_s_axis_tdata[2*PIX_W-1:PIX_W];

    // Advance the multiply stage when it is empty or the merge takes it
    assign w_en1           = !r_v1 || w_take;
    assign o_s_axis_tready = w_en1;
    assign w_in_fire       = i_s_axis_tvalid && w_en1;

    always_comb begin
        n_v1 = r_v1;
        if (w_en1) begin
            n_v1 = i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_eq1 <= (w_top == w_bottom);
        end
    end

    assign w_ctrl.load  = w_en1;
    assign w_ctrl.mode  = r_mode;
    assign w_ctrl.scale = r_scale;

    // One lane per color channel
    for (genvar g = 0; g < NUM_LANE; g++) begin : g_lane
        rbm_lane u_lane (
            .i_clk    (i_clk),
            .i_ctrl   (w_ctrl),
            .i_top    (w_top[g*CHAN_W +: CHAN_W]),
            .i_bottom (w_bottom[g*CHAN_W +: CHAN_W]),
            .o_result (w_lanes[g*CHAN_W +: CHAN_W])
        );
    end

    rbm_merge u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (r_v1),
        .i_lanes         (w_lanes),
        .i_equal         (r_eq1),
        .o_take          (w_take),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // A stalled multiply stage keeps its request
    `RBM_ASSERT(a_stage_hold, i_clk, i_rst_n, r_v1 && !w_take |=> r_v1)
    // An accepted request always lands in the multiply stage
    `RBM_ASSERT(a_fire_lands, i_clk, i_rst_n, w_in_fire |=> r_v1)
    // Reset leaves no result on the output
    `RBM_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_m_axis_tvalid && !r_v1)

endmodule

### test/tb_rgb_blend_mode_unit.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench for the RGB blend mode unit
// Streams top/bottom pixel pairs through the unit with bursty input and a
// stalling output, predicts every blended pixel and its equal flag in all
// four modes, and compares each result in order. Mode and gain are changed
// between phases while the stream is drained.
// ---------------------------------------------------------------------------
module tb_rgb_blend_mode_unit;
    import rbm_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 12;
    localparam int DRAIN_CYCLES  = 6;
    localparam int HOLDOFF_LEN   = 200;
    localparam int STALL_LIMIT   = 5000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 60;
    localparam int REPORT_MAX    = 10;

    // Layout mirrors the slave tdata: top_red in the lowest byte
    typedef struct packed {
        logic [CHAN_W-1:0] bottom_blue;
        logic [CHAN_W-1:0] bottom_green;
        logic [CHAN_W-1:0] bottom_red;
        logic [CHAN_W-1:0] top_blue;
        logic [CHAN_W-1:0] top_green;
        logic [CHAN_W-1:0] top_red;
    } pixel_pair_t;

    // Layout mirrors {tuser, tdata} of the master side
    typedef struct packed {
        logic              equal;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } blend_result_t;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_cfg_we;
    logic [CFG_IDX_W-1:0]                i_cfg_index;
    logic [CFG_DAT_W-1:0]                i_cfg_wdata;
    logic                                i_s_axis_tvalid;
    logic                                o_s_axis_tready;
    logic [2*NUM_LANE*CHAN_W-1:0]        i_s_axis_tdata;
    logic                                o_m_axis_tvalid;
    logic                                i_m_axis_tready;
    logic [NUM_LANE*CHAN_W-1:0]          o_m_axis_tdata;
    logic                                o_m_axis_tuser;

    // Predictor copy of the registers
    t_mode               cur_mode;
    logic [SCALE_W-1:0]  cur_scale;

    blend_result_t       pending_pixels[$];
    int                  mismatch_count;
    int                  pairs_sent;
    int                  results_checked;
    int                  cfg_writes;
    int                  burst_left;
    logic                holdoff_req;

    rgb_blend_mode_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    // Blend one channel of top a with bottom b, exact rounding half up
    function automatic logic [CHAN_W-1:0] blend_lane(input t_mode mode,
                                                     input logic [SCALE_W-1:0] gain,
                                                     input logic [CHAN_W-1:0] a,
                                                     input logic [CHAN_W-1:0] b);
        int unsigned ua;
        int unsigned ub;
        int unsigned ug;
        int unsigned r;
        int unsigned y;
        ua = 32'(a);
        ub = 32'(b);
        ug = 32'(gain);
        case (mode)
            MODE_MULTIPLY: r = (2 * ua * ub + 255) / 510;
            MODE_SUBTRACT: r = (ua > ub) ? ua - ub : 0;
            MODE_SCALE:    r = (ua * ug + 128) >> 8;
            default: begin
                if (ub <= 127) begin
                    r = (4 * ua * ub + 255) / 510;
                end else begin
                    y = (4 * (255 - ua) * (255 - ub) + 255) / 510;
                    r = (y >= 255) ? 0 : 255 - y;
                end
            end
        endcase
        return (r > 255) ? CHAN_MAX : r[CHAN_W-1:0];
    endfunction

    function automatic blend_result_t predict_blend(input pixel_pair_t p);
        blend_result_t res;
        res.red   = blend_lane(cur_mode, cur_scale, p.top_red,   p.bottom_red);
        res.green = blend_lane(cur_mode, cur_scale, p.top_green, p.bottom_green);
        res.blue  = blend_lane(cur_mode, cur_scale, p.top_blue,  p.bottom_blue);
        res.equal = (p.top_red == p.bottom_red) && (p.top_green == p.bottom_green)
                    && (p.top_blue == p.bottom_blue);
        return res;
    endfunction

    function automatic pixel_pair_t pair_of(input logic [7:0] tr, input logic [7:0] tg,
                                            input logic [7:0] tb, input logic [7:0] br,
                                            input logic [7:0] bg, input logic [7:0] bb);
        pixel_pair_t p;
        p.top_red      = tr;
        p.top_green    = tg;
        p.top_blue     = tb;
        p.bottom_red   = br;
        p.bottom_green = bg;
        p.bottom_blue  = bb;
        return p;
    endfunction

    function automatic logic [CHAN_W-1:0] corner_value();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd127;
            3:       return 8'd128;
            4:       return 8'd254;
            default: return 8'd255;
        endcase
    endfunction

    // Mostly uniform pairs, with equal, near-equal, corner and overlay-edge cases
    function automatic pixel_pair_t random_pair();
        pixel_pair_t p;
        p = pixel_pair_t'(48'({$urandom(), $urandom()}));
        case ($urandom_range(0, 9))
            6: begin
                p.bottom_red   = p.top_red;
                p.bottom_green = p.top_green;
                p.bottom_blue  = p.top_blue;
            end
            7: begin
                p = pair_of(corner_value(), corner_value(), corner_value(),
                            corner_value(), corner_value(), corner_value());
            end
            8: begin
                p.bottom_red   = p.top_red;
                p.bottom_green = p.top_green;
                p.bottom_blue  = p.top_blue;
                case ($urandom_range(0, 2))
                    0:       p.bottom_red   ^= 8'($urandom_range(1, 255));
                    1:       p.bottom_green ^= 8'($urandom_range(1, 255));
                    default: p.bottom_blue  ^= 8'($urandom_range(1, 255));
                endcase
            end
            9: begin
                p.bottom_red   = 8'($urandom_range(120, 135));
                p.bottom_green = 8'($urandom_range(120, 135));
                p.bottom_blue  = 8'($urandom_range(120, 135));
            end
            default: ;
        endcase
        return p;
    endfunction

    // Offer one request and hold it until accepted; idle between bursts
    task automatic send_pixels(input pixel_pair_t p);
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= p;
        do @(posedge i_clk); while (!o_s_axis_tready);
        burst_left--;
        if (burst_left <= 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= 48'({$urandom(), $urandom()});
            repeat ($urandom_range(0, 5)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 16);
        end
    endtask

    // Drop valid and wait until every predicted pixel has come back
    task automatic wait_drained();
        if (i_s_axis_tvalid) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
        end
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == REG_BLEND_MODE)
            cur_mode = t_mode'(value[1:0]);
        else
            cur_scale = value;
        cfg_writes++;
    endtask

    task automatic set_mode(input t_mode mode);
        write_reg(REG_BLEND_MODE, CFG_DAT_W'(mode));
    endtask

    // Multiply after reset, then scale mode with the reset gain of 1.0
    task automatic test_reset_defaults();
        send_pixels(pair_of(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_pixels(pair_of(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
        send_pixels(pair_of(8'd255, 8'd1, 8'd128, 8'd0, 8'd1, 8'd255));
        wait_drained();
        set_mode(MODE_SCALE);
        send_pixels(pair_of(8'd0, 8'd77, 8'd255, 8'd9, 8'd9, 8'd9));
        send_pixels(pair_of(8'd1, 8'd128, 8'd254, 8'd1, 8'd128, 8'd254));
        wait_drained();
    endtask

    // Saturation at zero and the plain difference
    task automatic test_subtract_saturation();
        set_mode(MODE_SUBTRACT);
        send_pixels(pair_of(8'd255, 8'd0, 8'd100, 8'd0, 8'd255, 8'd100));
        send_pixels(pair_of(8'd1, 8'd200, 8'd17, 8'd2, 8'd199, 8'd17));
        wait_drained();
    endtask

    // Zero gain, full gain with overflow clamp, and half-way ties
    task automatic test_scale_extremes();
        set_mode(MODE_SCALE);
        write_reg(REG_SCALE_FACTOR, 16'h0000);
        send_pixels(pair_of(8'd255, 8'd128, 8'd1, 8'd3, 8'd4, 8'd5));
        wait_drained();
        write_reg(REG_SCALE_FACTOR, 16'hFFFF);
        send_pixels(pair_of(8'd0, 8'd1, 8'd255, 8'd0, 8'd1, 8'd255));
        wait_drained();
        write_reg(REG_SCALE_FACTOR, 16'h0080);
        send_pixels(pair_of(8'd1, 8'd3, 8'd255, 8'd7, 8'd7, 8'd7));
        wait_drained();
        write_reg(REG_SCALE_FACTOR, 16'h0180);
        send_pixels(pair_of(8'd1, 8'd170, 8'd171, 8'd0, 8'd0, 8'd0));
        wait_drained();
    endtask

    // Both overlay branches around the bottom threshold
    task automatic test_overlay_branches();
        set_mode(MODE_OVERLAY);
        send_pixels(pair_of(8'd255, 8'd0, 8'd200, 8'd127, 8'd127, 8'd127));
        send_pixels(pair_of(8'd255, 8'd0, 8'd200, 8'd128, 8'd128, 8'd128));
        send_pixels(pair_of(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255));
        send_pixels(pair_of(8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128));
        wait_drained();
    endtask

    // Phases of random pixels, each with its own mode and gain
    task automatic test_random_traffic();
        logic [SCALE_W-1:0] gain;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(0, 4))
                0:       gain = 16'h0000;
                1:       gain = 16'hFFFF;
                2:       gain = SCALE_RESET;
                3:       gain = 16'($urandom_range(0, 511));
                default: gain = 16'($urandom());
            endcase
            if ($urandom_range(0, 1)) begin
                write_reg(REG_SCALE_FACTOR, gain);
                set_mode(t_mode'(2'(phase)));
            end else begin
                set_mode(t_mode'(2'(phase)));
                write_reg(REG_SCALE_FACTOR, gain);
            end
            repeat (PHASE_ITEMS) send_pixels(random_pair());
            wait_drained();
        end
    endtask

    // Hold the output off for a long stretch while requests keep coming
    task automatic test_output_holdoff();
        set_mode(MODE_OVERLAY);
        holdoff_req = 1'b1;
        repeat (24) send_pixels(random_pair());
        wait_drained();
    endtask

    // Output stall pattern, changing style every so often
    initial begin : sink_pattern
        int phase_left;
        int style;
        int period;
        int tick;
        phase_left = 0;
        style = 0;
        period = 2;
        tick = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holdoff_req) begin
                holdoff_req = 1'b0;
                i_m_axis_tready <= 1'b0;
                repeat (HOLDOFF_LEN - 1) @(negedge i_clk);
            end else begin
                if (phase_left == 0) begin
                    style = $urandom_range(0, 3);
                    period = $urandom_range(2, 5);
                    phase_left = $urandom_range(30, 200);
                end
                phase_left--;
                tick++;
                case (style)
                    0:       i_m_axis_tready <= 1'b1;
                    1:       i_m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       i_m_axis_tready <= ($urandom_range(0, 9) < 8);
                    default: i_m_axis_tready <= ((tick % period) != 0);
                endcase
            end
        end
    end

    // Predict on each accepted request, then check each accepted result
    always @(posedge i_clk) begin : scoreboard
        blend_result_t got;
        blend_result_t want;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                pending_pixels.push_back(predict_blend(pixel_pair_t'(i_s_axis_tdata)));
                pairs_sent++;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = {o_m_axis_tuser, o_m_axis_tdata};
                if (pending_pixels.size() == 0) begin
                    if (mismatch_count < REPORT_MAX)
                        $display("ERROR: unexpected result rgb=%h eq=%b",
                                 o_m_axis_tdata, o_m_axis_tuser);
                    mismatch_count++;
                end else begin
                    want = pending_pixels.pop_front();
                    results_checked++;
                    if (got !== want) begin
                        if (mismatch_count < REPORT_MAX) begin
                            $display("ERROR: result %0d expected r=%h g=%h b=%h eq=%b",
                                     results_checked, want.red, want.green, want.blue,
                                     want.equal);
                            $display("       got r=%h g=%h b=%h eq=%b",
                                     got.red, got.green, got.blue, got.equal);
                        end
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // End the run when nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("ERROR: no request moved for %0d cycles", STALL_LIMIT);
        $display("rgb_blend_mode_unit verification failed");
        $finish;
    end

    initial begin : main
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = REG_BLEND_MODE;
        i_cfg_wdata     = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        holdoff_req     = 1'b0;
        cur_mode        = MODE_MULTIPLY;
        cur_scale       = SCALE_RESET;
        mismatch_count  = 0;
        pairs_sent      = 0;
        results_checked = 0;
        cfg_writes      = 0;
        burst_left      = 1;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_reset_defaults();
        test_subtract_saturation();
        test_scale_extremes();
        test_overlay_branches();
        test_random_traffic();
        test_output_holdoff();
        wait_drained();

        $display("Covered %0d pixel pairs in all four modes; %0d results checked",
                 pairs_sent, results_checked);
        $display("%0d register writes, one %0d-cycle output hold-off; %0d mismatches",
                 cfg_writes, HOLDOFF_LEN, mismatch_count);
        if (mismatch_count == 0 && pending_pixels.size() == 0)
            $display("rgb_blend_mode_unit verification clean");
        else
            $display("rgb_blend_mode_unit verification failed");
        $finish;
    end

endmodule
